// ----- sv/tmcw_pkg.sv -----
package tmcw_pkg;

  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 25;
  localparam int CELLS         = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
  localparam int COL_W         = $clog2(SCREEN_WIDTH);
  localparam int ADDR_W        = $clog2(CELLS);
  localparam int FIELD_ROW_W   = 5;
  localparam int FIELD_COL_W   = 7;

  localparam logic [7:0]  NEWLINE_BYTE = 8'd10;
  localparam logic [7:0]  SPACE_BYTE   = 8'd32;
  localparam logic [7:0]  RESET_COLOR  = 8'h07;
  localparam logic [15:0] BLANK_CELL   = 16'h0720;

  typedef enum logic [3:0] {
    S_CLEAR    = 4'd0,
    S_IDLE     = 4'd1,
    S_DECODE   = 4'd2,
    S_PUT_CHK  = 4'd3,
    S_PUT_WR   = 4'd4,
    S_NEWLINE  = 4'd5,
    S_NEXT_ROW = 4'd6,
    S_BLANK    = 4'd7,
    S_FINISH   = 4'd8,
    S_READ     = 4'd9
  } step_t;

  typedef enum logic [3:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_CLEAR_BUSY,
    COND_IS_READ,
    COND_IS_NEWLINE,
    COND_NO_WRAP,
    COND_ROW_FREE,
    COND_BLANK_BUSY,
    COND_NO_ITEM,
    COND_OUT_BUSY
  } cond_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LATCH,
    OP_PUT,
    OP_COL_ZERO,
    OP_ROW_ADV,
    OP_BLANK,
    OP_READ,
    OP_LOAD_OUT
  } dp_op_t;

  typedef struct packed {
    logic   in_ready;
    cond_t  wait_cond;
    dp_op_t op;
    cond_t  jump_cond;
    step_t  target;
  } ucode_t;

  typedef struct packed {
    dp_op_t op;
    logic   go;
  } dp_ctrl_t;

  typedef struct packed {
    logic clear_busy;
    logic is_read;
    logic is_newline;
    logic no_wrap;
    logic row_free;
    logic blank_busy;
    logic out_busy;
  } dp_status_t;

  function automatic ucode_t uw(input logic rdy, input cond_t wc, input dp_op_t op,
                                input cond_t jc, input step_t tgt);
    ucode_t w;
    w.in_ready  = rdy;
    w.wait_cond = wc;
    w.op        = op;
    w.jump_cond = jc;
    w.target    = tgt;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input step_t s);
    ucode_t w;
    unique case (s)
      S_CLEAR:    w = uw(1'b0, COND_NONE,     OP_CLEAR,    COND_CLEAR_BUSY, S_CLEAR);
      S_IDLE:     w = uw(1'b1, COND_NO_ITEM,  OP_LATCH,    COND_NONE,       S_IDLE);
      S_DECODE:   w = uw(1'b0, COND_NONE,     OP_NONE,     COND_IS_READ,    S_READ);
      S_PUT_CHK:  w = uw(1'b0, COND_NONE,     OP_NONE,     COND_IS_NEWLINE, S_NEWLINE);
      S_PUT_WR:   w = uw(1'b0, COND_NONE,     OP_PUT,      COND_NO_WRAP,    S_FINISH);
      S_NEWLINE:  w = uw(1'b0, COND_NONE,     OP_COL_ZERO, COND_NONE,       S_NEWLINE);
      S_NEXT_ROW: w = uw(1'b0, COND_NONE,     OP_ROW_ADV,  COND_ROW_FREE,   S_FINISH);
      S_BLANK:    w = uw(1'b0, COND_NONE,     OP_BLANK,    COND_BLANK_BUSY, S_BLANK);
      S_FINISH:   w = uw(1'b0, COND_OUT_BUSY, OP_LOAD_OUT, COND_ALWAYS,     S_IDLE);
      S_READ:     w = uw(1'b0, COND_NONE,     OP_READ,     COND_ALWAYS,     S_FINISH);
      default:    w = uw(1'b0, COND_NONE,     OP_NONE,     COND_ALWAYS,     S_IDLE);
    endcase
    return w;
  endfunction

endpackage

// ----- sv/text_mode_console_writer_unit.sv -----
// Text console with an 80 by 25 store of 16-bit cells (attribute high, character low).
// Input channel in_valid/in_ready carries one item: operation 0 puts character at the
// cursor (10 is newline), operation 1 reads the cell at read_row/read_column.
// Output channel out_valid/out_ready returns one result per item: the cell read (zero
// for a put), the cursor after the item, and whether the item scrolled the screen.
// text_color_we writes text_color, the attribute used for new and blanked cells.
// A microcoded sequencer steps a single-port cell memory, one access per cycle.
// A read passes decode, read and finish, a put decode, check, write and finish; a
// newline (from check) or a wrap (after write) goes on through the newline and next-row
// steps, and a scroll adds a step that blanks the bottom row. One item is in work at a
// time; the next can be accepted in the cycle after its result is loaded. Rows are kept
// as a ring, so a scroll moves no cells. After reset all SCREEN_WIDTH*SCREEN_HEIGHT
// (2000) cells are cleared to 0x0720, one cell per cycle, with in_ready low; text_color
// writes are still taken, and the cursor starts at row 0, column 0 with color 7.
// A result waits in the output register while out_ready is low; the next item may
// be accepted meanwhile, and its result is held back until the register is free.
module text_mode_console_writer_unit import tmcw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   text_color_we,
  input  logic [7:0]             text_color,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   operation,
  input  logic [7:0]             character,
  input  logic [FIELD_ROW_W-1:0] read_row,
  input  logic [FIELD_COL_W-1:0] read_column,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [15:0]            cell_data,
  output logic [FIELD_ROW_W-1:0] cursor_row_out,
  output logic [FIELD_COL_W-1:0] cursor_column_out,
  output logic                   scrolled
);

  dp_ctrl_t   ctrl;
  dp_status_t status;

  tmcw_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  tmcw_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .text_color_we     (text_color_we),
    .text_color        (text_color),
    .operation         (operation),
    .character         (character),
    .read_row          (read_row),
    .read_column       (read_column),
    .out_ready         (out_ready),
    .status            (status),
    .out_valid         (out_valid),
    .cell_data         (cell_data),
    .cursor_row_out    (cursor_row_out),
    .cursor_column_out (cursor_column_out),
    .scrolled          (scrolled)
  );

endmodule

// ----- sv/tmcw_seq.sv -----
module tmcw_seq import tmcw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t status,
  output logic       in_ready,
  output dp_ctrl_t   ctrl
);

  step_t  step;
  step_t  step_next;
  ucode_t uword;
  logic   waiting;
  logic   jump;

  function automatic logic cond_true(input cond_t c, input dp_status_t st, input logic item);
    logic r;
    unique case (c)
      COND_NONE:       r = 1'b0;
      COND_ALWAYS:     r = 1'b1;
      COND_CLEAR_BUSY: r = st.clear_busy;
      COND_IS_READ:    r = st.is_read;
      COND_IS_NEWLINE: r = st.is_newline;
      COND_NO_WRAP:    r = st.no_wrap;
      COND_ROW_FREE:   r = st.row_free;
      COND_BLANK_BUSY: r = st.blank_busy;
      COND_NO_ITEM:    r = !item;
      COND_OUT_BUSY:   r = st.out_busy;
      default:         r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    uword    = ucode_rom(step);
    waiting  = cond_true(uword.wait_cond, status, in_valid);
    jump     = cond_true(uword.jump_cond, status, in_valid);
    in_ready = uword.in_ready;
    ctrl.op  = uword.op;
    ctrl.go  = !waiting;
  end

  always_comb begin
    priority if (waiting) begin
      step_next = step;
    end else if (jump) begin
      step_next = uword.target;
    end else begin
      step_next = step_t'(step + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_CLEAR;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ----- sv/tmcw_datapath.sv -----
module tmcw_datapath import tmcw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_ctrl_t               ctrl,
  input  logic                   text_color_we,
  input  logic [7:0]             text_color,
  input  logic                   operation,
  input  logic [7:0]             character,
  input  logic [FIELD_ROW_W-1:0] read_row,
  input  logic [FIELD_COL_W-1:0] read_column,
  input  logic                   out_ready,
  output dp_status_t             status,
  output logic                   out_valid,
  output logic [15:0]            cell_data,
  output logic [FIELD_ROW_W-1:0] cursor_row_out,
  output logic [FIELD_COL_W-1:0] cursor_column_out,
  output logic                   scrolled
);

  logic [15:0]            mem [CELLS];
  logic [15:0]            rdata;
  logic [ADDR_W-1:0]      clr_addr;
  logic [ROW_W-1:0]       cursor_row;
  logic [ROW_W-1:0]       top_row;
  logic [COL_W-1:0]       cursor_column;
  logic [COL_W-1:0]       blank_col;
  logic [7:0]             color;
  logic                   item_read;
  logic [7:0]             item_char;
  logic [FIELD_ROW_W-1:0] item_row;
  logic [FIELD_COL_W-1:0] item_col;
  logic                   scroll_flag;
  logic                   in_range;
  logic [ADDR_W-1:0]      cur_addr;
  logic [ADDR_W-1:0]      bot_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  logic [15:0]            wdata;
  logic                   load_out;
  logic                   out_valid_next;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                               input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= (ROW_W+1)'(SCREEN_HEIGHT)) begin
      sum = sum - (ROW_W+1)'(SCREEN_HEIGHT);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                 input logic [COL_W-1:0] col);
    return ADDR_W'(ADDR_W'(prow) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col));
  endfunction

  // rows live in a ring: top_row is the physical row shown first
  always_comb begin
    in_range = (32'(item_row) < SCREEN_HEIGHT) && (32'(item_col) < SCREEN_WIDTH);
    cur_addr = cell_addr(phys_row(cursor_row, top_row), cursor_column);
    bot_addr = cell_addr(phys_row(ROW_W'(SCREEN_HEIGHT - 1), top_row), blank_col);
    rd_addr  = in_range ? cell_addr(phys_row(ROW_W'(item_row), top_row), COL_W'(item_col))
                        : '0;
  end

  always_comb begin
    status.clear_busy = clr_addr != ADDR_W'(CELLS - 1);
    status.is_read    = item_read;
    status.is_newline = item_char == NEWLINE_BYTE;
    status.no_wrap    = cursor_column != COL_W'(SCREEN_WIDTH - 1);
    status.row_free   = cursor_row != ROW_W'(SCREEN_HEIGHT - 1);
    status.blank_busy = blank_col != COL_W'(SCREEN_WIDTH - 1);
    status.out_busy   = out_valid && !out_ready;
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = {color, item_char};
    if (ctrl.go) begin
      unique case (ctrl.op)
        OP_CLEAR: begin
          we    = 1'b1;
          waddr = clr_addr;
          wdata = BLANK_CELL;
        end
        OP_PUT: begin
          we = 1'b1;
        end
        OP_BLANK: begin
          we    = 1'b1;
          waddr = bot_addr;
          wdata = {color, SPACE_BYTE};
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctrl.go && ctrl.op == OP_READ) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    load_out = ctrl.go && ctrl.op == OP_LOAD_OUT;
    priority if (load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr      <= '0;
      cursor_row    <= '0;
      cursor_column <= '0;
      top_row       <= '0;
      blank_col     <= '0;
      color         <= RESET_COLOR;
      out_valid     <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (text_color_we) begin
        color <= text_color;
      end
      if (ctrl.go) begin
        unique case (ctrl.op)
          OP_CLEAR: begin
            clr_addr <= ADDR_W'(clr_addr + 1'b1);
          end
          OP_PUT: begin
            cursor_column <= status.no_wrap ? COL_W'(cursor_column + 1'b1) : '0;
          end
          OP_COL_ZERO: begin
            cursor_column <= '0;
          end
          OP_ROW_ADV: begin
            if (status.row_free) begin
              cursor_row <= ROW_W'(cursor_row + 1'b1);
            end else begin
              top_row   <= (top_row == ROW_W'(SCREEN_HEIGHT - 1)) ? '0
                                                                  : ROW_W'(top_row + 1'b1);
              blank_col <= '0;
            end
          end
          OP_BLANK: begin
            blank_col <= COL_W'(blank_col + 1'b1);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      unique case (ctrl.op)
        OP_LATCH: begin
          item_read   <= operation;
          item_char   <= character;
          item_row    <= read_row;
          item_col    <= read_column;
          scroll_flag <= 1'b0;
        end
        OP_ROW_ADV: begin
          if (!status.row_free) begin
            scroll_flag <= 1'b1;
          end
        end
        OP_LOAD_OUT: begin
          cell_data         <= (item_read && in_range) ? rdata : '0;
          cursor_row_out    <= FIELD_ROW_W'(cursor_row);
          cursor_column_out <= FIELD_COL_W'(cursor_column);
          scrolled          <= scroll_flag;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- sv/tmcw_checker.sv -----
module tmcw_checker import tmcw_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [15:0]            cell_data,
  input logic [FIELD_ROW_W-1:0] cursor_row_out,
  input logic [FIELD_COL_W-1:0] cursor_column_out,
  input logic                   scrolled
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("item accepted during memory clear");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_data)
      && $stable(cursor_row_out) && $stable(cursor_column_out) && $stable(scrolled))
    else $error("stalled result changed");

  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> cursor_row_out == FIELD_ROW_W'(SCREEN_HEIGHT - 1)
      && cursor_column_out == '0)
    else $error("scroll left cursor off the last row start");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(cursor_column_out) < SCREEN_WIDTH
      && 32'(cursor_row_out) < SCREEN_HEIGHT)
    else $error("cursor outside the screen");

endmodule

bind text_mode_console_writer_unit tmcw_checker u_checker (.*);

// ----- sim/text_mode_console_writer_unit_tb.sv -----
`timescale 1ns / 100ps

module text_mode_console_writer_unit_tb;
  import tmcw_pkg::*;

  localparam logic OPER_PUT  = 1'b0;
  localparam logic OPER_READ = 1'b1;
  localparam int   PHASES    = 6;
  localparam int   RANDOM_PER_PHASE = 240;

  typedef struct packed {
    logic                   operation;
    logic [7:0]             character;
    logic [FIELD_ROW_W-1:0] read_row;
    logic [FIELD_COL_W-1:0] read_column;
  } console_item_t;

  typedef struct packed {
    logic [15:0]            cell_data;
    logic [FIELD_ROW_W-1:0] cursor_row;
    logic [FIELD_COL_W-1:0] cursor_column;
    logic                   scrolled;
  } console_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_color = 8'h00;
  logic in_valid = 1'b0;
  logic in_ready;
  console_item_t drv_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] cell_data;
  logic [FIELD_ROW_W-1:0] cursor_row_out;
  logic [FIELD_COL_W-1:0] cursor_column_out;
  logic scrolled;

  console_item_t   pending_items[$];
  console_result_t expected_results[$];

  logic [15:0] shadow_cells [0:CELLS-1];
  int          shadow_row;
  int          shadow_col;
  logic [7:0]  shadow_color;

  logic in_fire = 1'b0;
  int   burst_left = 0;
  int   gap_left = 0;
  int   stall_mode = 0;
  int   stall_left = 0;

  int errors = 0;
  int items_queued = 0;
  int results_checked = 0;
  int reads_checked = 0;
  int scrolls_checked = 0;
  int wraps_checked = 0;

  text_mode_console_writer_unit u_top (
    .clk              (clk),
    .rst              (rst),
    .text_color_we    (cfg_we),
    .text_color       (cfg_color),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (drv_item.operation),
    .character        (drv_item.character),
    .read_row         (drv_item.read_row),
    .read_column      (drv_item.read_column),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .cell_data        (cell_data),
    .cursor_row_out   (cursor_row_out),
    .cursor_column_out(cursor_column_out),
    .scrolled         (scrolled)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic advance_row();
    shadow_row++;
    if (shadow_row >= SCREEN_HEIGHT) begin
      for (int i = 0; i < CELLS - SCREEN_WIDTH; i++)
        shadow_cells[i] = shadow_cells[i + SCREEN_WIDTH];
      for (int x = 0; x < SCREEN_WIDTH; x++)
        shadow_cells[(SCREEN_HEIGHT - 1) * SCREEN_WIDTH + x] = {shadow_color, SPACE_BYTE};
      shadow_row = SCREEN_HEIGHT - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic console_result_t apply_console_item(console_item_t it);
    console_result_t r;
    r = '0;
    if (it.operation == OPER_READ) begin
      if (int'(it.read_row) < SCREEN_HEIGHT && int'(it.read_column) < SCREEN_WIDTH)
        r.cell_data = shadow_cells[int'(it.read_row) * SCREEN_WIDTH + int'(it.read_column)];
    end else if (it.character == NEWLINE_BYTE) begin
      shadow_col = 0;
      r.scrolled = advance_row();
    end else begin
      shadow_cells[shadow_row * SCREEN_WIDTH + shadow_col] = {shadow_color, it.character};
      shadow_col++;
      if (shadow_col >= SCREEN_WIDTH) begin
        shadow_col = 0;
        r.scrolled = advance_row();
      end
    end
    r.cursor_row    = shadow_row[FIELD_ROW_W-1:0];
    r.cursor_column = shadow_col[FIELD_COL_W-1:0];
    return r;
  endfunction

  // sender: bursts of items with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        drv_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: out_ready follows one of four stall modes, chosen anew at random
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    unique case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 1) == 1);
      end
      2: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
      default: begin
        out_ready <= ~out_ready;
      end
    endcase
  end

  always @(posedge clk) begin
    console_result_t got;
    console_result_t want;
    in_fire <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) expected_results.push_back(apply_console_item(drv_item));
      if (out_valid && out_ready) begin
        got = {cell_data, cursor_row_out, cursor_column_out, scrolled};
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: cell=%h row=%0d col=%0d scrolled=%0b",
                   $time, got.cell_data, got.cursor_row, got.cursor_column, got.scrolled);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch: expected cell=%h row=%0d col=%0d scrolled=%0b", $time,
                     want.cell_data, want.cursor_row, want.cursor_column, want.scrolled);
            $display("%0t:           actual   cell=%h row=%0d col=%0d scrolled=%0b", $time,
                     got.cell_data, got.cursor_row, got.cursor_column, got.scrolled);
          end
          if (want.scrolled) scrolls_checked++;
          if (want.cell_data != 16'h0000) reads_checked++;
          if (want.cursor_column == 0 && !want.scrolled && want.cell_data == 16'h0000)
            wraps_checked++;
        end
      end
    end
  end

  task automatic queue_item(input logic op, input logic [7:0] ch, input int row, input int col);
    console_item_t it;
    it.operation   = op;
    it.character   = ch;
    it.read_row    = row[FIELD_ROW_W-1:0];
    it.read_column = col[FIELD_COL_W-1:0];
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic put_char(input logic [7:0] ch);
    queue_item(OPER_PUT, ch, $urandom_range(0, 31), $urandom_range(0, 127));
  endtask

  task automatic read_cell(input int row, input int col);
    queue_item(OPER_READ, 8'($urandom_range(0, 255)), row, col);
  endtask

  task automatic wait_console_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_text_color(input logic [7:0] color);
    wait_console_idle();
    repeat (10) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_color <= color;
    @(negedge clk);
    cfg_we <= 1'b0;
    shadow_color = color;
  endtask

  task automatic queue_random_traffic(input int count);
    int stop_at;
    int len;
    int kind;
    logic [7:0] ch;
    stop_at = items_queued + count;
    while (items_queued < stop_at) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        len = $urandom_range(1, 90);
        repeat (len) begin
          do ch = 8'($urandom_range(0, 255)); while (ch == NEWLINE_BYTE);
          put_char(ch);
        end
        if ($urandom_range(0, 9) < 7) put_char(NEWLINE_BYTE);
      end else if (kind < 65) begin
        repeat ($urandom_range(1, 30)) put_char(NEWLINE_BYTE);
      end else if (kind < 90) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 2) == 0)
            read_cell(SCREEN_HEIGHT - 1, $urandom_range(0, SCREEN_WIDTH - 1));
          else
            read_cell($urandom_range(0, SCREEN_HEIGHT - 1), $urandom_range(0, SCREEN_WIDTH - 1));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          queue_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     $urandom_range(0, 31), $urandom_range(0, 127));
      end
    end
  endtask

  initial begin
    logic [7:0] phase_color [PHASES];
    for (int i = 0; i < CELLS; i++) shadow_cells[i] = BLANK_CELL;
    shadow_row   = 0;
    shadow_col   = 0;
    shadow_color = RESET_COLOR;
    phase_color[0] = 8'h1E;
    phase_color[1] = 8'hFF;
    phase_color[2] = 8'h00;
    phase_color[3] = 8'($urandom_range(0, 255));
    phase_color[4] = 8'($urandom_range(0, 255));
    phase_color[5] = RESET_COLOR;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      write_text_color(phase_color[p]);
      if (p == 0) begin
        read_cell(0, 0);
        read_cell(SCREEN_HEIGHT - 1, SCREEN_WIDTH - 1);
        read_cell(SCREEN_HEIGHT, 0);
        read_cell(31, 127);
        read_cell(0, SCREEN_WIDTH);
        read_cell(0, 127);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        put_char(SPACE_BYTE);
        put_char(NEWLINE_BYTE);
        put_char(8'h7F);
        put_char(8'h80);
        read_cell(0, 0);
        read_cell(0, 1);
        read_cell(0, 2);
        read_cell(0, 3);
        read_cell(1, 0);
        put_char(NEWLINE_BYTE);
        put_char(NEWLINE_BYTE);
        read_cell(2, 0);
      end
      queue_random_traffic(RANDOM_PER_PHASE);
    end

    wait_console_idle();
    repeat (100) @(posedge clk);
    $display("Ran %0d items over %0d text colors; %0d results checked", items_queued, PHASES,
             results_checked);
    $display("Nonzero cell reads %0d, scrolls %0d, column returns %0d", reads_checked,
             scrolls_checked, wraps_checked);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- text_mode_console_writer_unit.f -----
sv/tmcw_pkg.sv
sv/tmcw_seq.sv
sv/tmcw_datapath.sv
sv/text_mode_console_writer_unit.sv
sv/tmcw_checker.sv
sim/text_mode_console_writer_unit_tb.sv
